// File: sv/wris_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weighted random index select package
// Shared widths, defaults and the control group that drives the weight cells.
// ----------------------------------------------------------------------------
package wris_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int SLOT_W  = 4;
    localparam int VALUE_W = 16;
    localparam int EXCL_W  = 8;
    localparam int COUNT_W = 5;
    localparam int DRAW_W  = 16;
    localparam int INDEX_W = 4;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SELECT = 1'b1;

    typedef struct packed {
        logic              shift;
        logic              wr;
        logic [SLOT_W-1:0] slot;
    } cell_ctrl_t;

endpackage : wris_pkg
`default_nettype wire

// File: sv/wris_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weight cell
// Holds one table weight; loads it on a matching write and passes it to the
// neighbor cell when the ring rotates.
// ----------------------------------------------------------------------------
module wris_cell #(
    parameter int CELL_IDX    = 0,
    parameter int WEIGHT_BITS = wris_pkg::WEIGHT_BITS_DEF
) (
    input  wire                         clk,
    input  wire wris_pkg::cell_ctrl_t   ctrl,
    input  wire logic [WEIGHT_BITS-1:0] wr_data,
    input  wire logic [WEIGHT_BITS-1:0] neighbor_w,
    output logic      [WEIGHT_BITS-1:0] weight
);

    logic [WEIGHT_BITS-1:0] weight_reg;
    logic [WEIGHT_BITS-1:0] weight_next;
    logic                   hit;

    assign hit = ctrl.wr && (int'(ctrl.slot) == CELL_IDX);

    always_comb
    begin
        weight_next = weight_reg;
        if (ctrl.shift)
        begin
            weight_next = neighbor_w;
        end
        else if (hit)
        begin
            weight_next = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
    end

    assign weight = weight_reg;

endmodule : wris_cell
`default_nettype wire

// File: sv/weighted_random_index_select_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weighted random index select unit
// Roulette-wheel selection over a ring of weight cells.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_ready  | req_type, entry_slot, weight_value,
//           |                      | exclude_index, entry_limit, random_draw
//  out      | out_valid / out_ready| chosen_index, no_draw
//  cfg      | cfg_wr_en            | cfg_wr_data (entry_count)
//
// A weight write word is stored while the unit stays idle. A select word runs
// through S_SUM, one rotation of the cell ring to sum, S_MUL to scale the draw,
// S_SEARCH, a second rotation to search, and S_DONE to load the output register;
// the input is ready again in S_IDLE; a select with no draw reaches S_DONE early.
// Reset clears the control state and entry_count; weights are valid once written.
// A stalled output holds the result while the unit waits in its final state.
// ----------------------------------------------------------------------------
module weighted_random_index_select_unit #(
    parameter int MAX_ENTRIES = wris_pkg::MAX_ENTRIES_DEF,
    parameter int WEIGHT_BITS = wris_pkg::WEIGHT_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_wr_en,
    input  wire logic [wris_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire logic                           req_type,
    input  wire logic [wris_pkg::SLOT_W-1:0]    entry_slot,
    input  wire logic [wris_pkg::VALUE_W-1:0]   weight_value,
    input  wire logic [wris_pkg::EXCL_W-1:0]    exclude_index,
    input  wire logic [wris_pkg::COUNT_W-1:0]   entry_limit,
    input  wire logic [wris_pkg::DRAW_W-1:0]    random_draw,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic      [wris_pkg::INDEX_W-1:0]   chosen_index,
    output logic                                no_draw
);

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = ($clog2(MAX_ENTRIES + 1) > wris_pkg::COUNT_W) ?
                            $clog2(MAX_ENTRIES + 1) : wris_pkg::COUNT_W;
    localparam int SUM_W  = WEIGHT_BITS + IDX_W + 2;
    localparam int PROD_W = wris_pkg::DRAW_W + SUM_W - 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SUM    = 5'b00010,
        S_MUL    = 5'b00100,
        S_SEARCH = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [wris_pkg::COUNT_W-1:0]  entry_count_reg, entry_count_next;
    logic [CNT_W-1:0]              n_reg, n_next;
    logic [wris_pkg::EXCL_W-1:0]   excl_reg, excl_next;
    logic [wris_pkg::DRAW_W-1:0]   draw_reg, draw_next;
    logic [IDX_W-1:0]              pos_reg, pos_next;
    logic signed [SUM_W-1:0]       total_reg, total_next;
    logic signed [SUM_W-1:0]       rem_reg, rem_next;
    logic                          found_reg, found_next;
    logic [wris_pkg::INDEX_W-1:0]  res_idx_reg, res_idx_next;
    logic                          res_nd_reg, res_nd_next;
    logic                          out_valid_reg, out_valid_next;
    logic [wris_pkg::INDEX_W-1:0]  chosen_index_reg, chosen_index_next;
    logic                          no_draw_reg, no_draw_next;

    wris_pkg::cell_ctrl_t          cell_ctrl;
    logic [WEIGHT_BITS-1:0]        ring_w [MAX_ENTRIES];
    logic [WEIGHT_BITS-1:0]        wr_data;

    logic                          in_fire;
    logic                          last_pos;
    logic                          active;
    logic                          excl_hit;
    logic signed [SUM_W-1:0]       w_eff;
    logic signed [SUM_W-1:0]       diff;
    logic [PROD_W-1:0]             prod;
    logic [CNT_W-1:0]              n_sel;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign wr_data  = WEIGHT_BITS'(weight_value);

    assign cell_ctrl = '{
        shift: (state_reg == S_SUM) || (state_reg == S_SEARCH),
        wr:    in_fire && (req_type == wris_pkg::REQ_WRITE),
        slot:  entry_slot
    };

    for (genvar k = 0; k < MAX_ENTRIES; k++)
    begin : g_cell
        wris_cell #(
            .CELL_IDX    (k),
            .WEIGHT_BITS (WEIGHT_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .wr_data    (wr_data),
            .neighbor_w (ring_w[(k + 1) % MAX_ENTRIES]),
            .weight     (ring_w[k])
        );
    end

    assign last_pos = (pos_reg == IDX_W'(MAX_ENTRIES - 1));
    assign active   = (CNT_W'(pos_reg) < n_reg);
    assign excl_hit = (excl_reg == wris_pkg::EXCL_W'(pos_reg));
    assign w_eff    = $signed(SUM_W'(ring_w[0])) - $signed(SUM_W'(excl_hit));
    assign diff     = rem_reg - w_eff;
    assign prod     = PROD_W'(draw_reg) * PROD_W'(total_reg[SUM_W-2:0]);

    always_comb
    begin
        n_sel = CNT_W'(entry_count_reg);
        if (CNT_W'(entry_limit) < n_sel)
        begin
            n_sel = CNT_W'(entry_limit);
        end
        if (CNT_W'(MAX_ENTRIES) < n_sel)
        begin
            n_sel = CNT_W'(MAX_ENTRIES);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        entry_count_next  = entry_count_reg;
        n_next            = n_reg;
        excl_next         = excl_reg;
        draw_next         = draw_reg;
        pos_next          = pos_reg;
        total_next        = total_reg;
        rem_next          = rem_reg;
        found_next        = found_reg;
        res_idx_next      = res_idx_reg;
        res_nd_next       = res_nd_reg;
        out_valid_next    = out_valid_reg;
        chosen_index_next = chosen_index_reg;
        no_draw_next      = no_draw_reg;

        if (cfg_wr_en)
        begin
            entry_count_next = cfg_wr_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (req_type == wris_pkg::REQ_SELECT))
                begin
                    n_next       = n_sel;
                    excl_next    = exclude_index;
                    draw_next    = random_draw;
                    pos_next     = '0;
                    total_next   = '0;
                    res_idx_next = '0;
                    res_nd_next  = 1'b0;
                    if (n_sel < CNT_W'(2))
                    begin
                        res_nd_next = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                if (active)
                begin
                    total_next = total_reg + w_eff;
                end
                pos_next = last_pos ? '0 : pos_reg + IDX_W'(1);
                if (last_pos)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                found_next = 1'b0;
                if (total_reg < $signed(SUM_W'(1)))
                begin
                    res_nd_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    rem_next   = $signed(SUM_W'(prod >> wris_pkg::DRAW_W));
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (active && !found_reg)
                begin
                    rem_next = diff;
                    if (diff < $signed(SUM_W'(0)))
                    begin
                        found_next   = 1'b1;
                        res_idx_next = wris_pkg::INDEX_W'(pos_reg);
                    end
                end
                pos_next = last_pos ? '0 : pos_reg + IDX_W'(1);
                if (last_pos)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    chosen_index_next = res_idx_reg;
                    no_draw_next      = res_nd_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            pos_reg         <= '0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            pos_reg         <= pos_next;
            found_reg       <= found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg            <= n_next;
        excl_reg         <= excl_next;
        draw_reg         <= draw_next;
        total_reg        <= total_next;
        rem_reg          <= rem_next;
        res_idx_reg      <= res_idx_next;
        res_nd_reg       <= res_nd_next;
        chosen_index_reg <= chosen_index_next;
        no_draw_reg      <= no_draw_next;
    end

    assign out_valid    = out_valid_reg;
    assign chosen_index = chosen_index_reg;
    assign no_draw      = no_draw_reg;

endmodule : weighted_random_index_select_unit
`default_nettype wire

// File: sv/wris_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weighted random index select port checker
// Watches the ports of the top level and flags handshake or result slips.
// ----------------------------------------------------------------------------
module wris_checker (
    input wire                                 clk,
    input wire                                 rst_n,
    input wire                                 in_valid,
    input wire                                 in_ready,
    input wire logic                           req_type,
    input wire logic [wris_pkg::SLOT_W-1:0]    entry_slot,
    input wire logic [wris_pkg::VALUE_W-1:0]   weight_value,
    input wire logic [wris_pkg::EXCL_W-1:0]    exclude_index,
    input wire logic [wris_pkg::COUNT_W-1:0]   entry_limit,
    input wire logic [wris_pkg::DRAW_W-1:0]    random_draw,
    input wire                                 out_valid,
    input wire                                 out_ready,
    input wire logic [wris_pkg::INDEX_W-1:0]   chosen_index,
    input wire                                 no_draw
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(chosen_index) && $stable(no_draw))
        else $error("Stalled output word changed or dropped.");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable({req_type, entry_slot, weight_value,
                                                       exclude_index, entry_limit,
                                                       random_draw}))
        else $error("Waiting input word changed or dropped.");

    a_no_draw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_draw |-> chosen_index == '0)
        else $error("A word without a draw carries a nonzero index.");

    a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == wris_pkg::REQ_SELECT) |=> !in_ready)
        else $error("Input taken while a select is in progress.");

    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == wris_pkg::REQ_WRITE) |=> in_ready)
        else $error("A weight write did not complete in one cycle.");

endmodule : wris_checker

bind weighted_random_index_select_unit wris_checker u_wris_checker (.*);
`default_nettype wire

// File: tb/sv/weighted_random_index_select_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted random index select unit testbench
// Fills the weight table, drives weight writes and weighted selects over the
// valid/ready input channel, and changes entry_count only while the unit is
// idle. Each select is predicted from a local copy of the weights and the
// entry count. The returned index and no_draw flag are checked in order of
// arrival against that prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module weighted_random_index_select_unit_tb;

    localparam int SETTLE_CYCLES  = 2 * wris_pkg::MAX_ENTRIES_DEF + 8;
    localparam int STALL_LIMIT    = 3000;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic [wris_pkg::INDEX_W-1:0] index;
        logic                         no_pick;
    } pick_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [wris_pkg::COUNT_W-1:0]   cfg_wr_data;
    logic                           in_valid;
    logic                           in_ready;
    logic                           req_type;
    logic [wris_pkg::SLOT_W-1:0]    entry_slot;
    logic [wris_pkg::VALUE_W-1:0]   weight_value;
    logic [wris_pkg::EXCL_W-1:0]    exclude_index;
    logic [wris_pkg::COUNT_W-1:0]   entry_limit;
    logic [wris_pkg::DRAW_W-1:0]    random_draw;
    logic                           out_valid;
    logic                           out_ready;
    logic [wris_pkg::INDEX_W-1:0]   chosen_index;
    logic                           no_draw;

    logic [wris_pkg::VALUE_W-1:0]   weight_mem [wris_pkg::MAX_ENTRIES_DEF];
    logic [wris_pkg::COUNT_W-1:0]   entry_count_m;
    pick_t                          expected_picks [$];
    int                             error_count;
    int                             quiet_cycles;
    int                             tx_idle_pct;
    int                             rx_idle_pct;
    int                             rx_hold_left;
    logic                           in_taken;

    weighted_random_index_select_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .entry_slot    (entry_slot),
        .weight_value  (weight_value),
        .exclude_index (exclude_index),
        .entry_limit   (entry_limit),
        .random_draw   (random_draw),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .chosen_index  (chosen_index),
        .no_draw       (no_draw)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint entry_weight(input int i,
                                            input logic [wris_pkg::EXCL_W-1:0] excl);
        return longint'(weight_mem[i]) - ((i == excl) ? 1 : 0);
    endfunction

    function automatic pick_t predict_pick(input logic [wris_pkg::EXCL_W-1:0] excl,
                                           input logic [wris_pkg::COUNT_W-1:0] lim,
                                           input logic [wris_pkg::DRAW_W-1:0] draw);
        pick_t  res;
        int     active;
        longint sum;
        longint target;
        res = '0;
        active = entry_count_m;
        if (active > lim)
            active = lim;
        if (active > wris_pkg::MAX_ENTRIES_DEF)
            active = wris_pkg::MAX_ENTRIES_DEF;
        if (active < 2)
        begin
            res.no_pick = 1'b1;
            return res;
        end
        sum = 0;
        for (int i = 0; i < active; i++)
            sum += entry_weight(i, excl);
        if (sum < 1)
        begin
            res.no_pick = 1'b1;
            return res;
        end
        target = (longint'(draw) * sum) >>> 16;
        for (int i = 0; i < active; i++)
        begin
            target -= entry_weight(i, excl);
            if (target < 0)
            begin
                res.index = wris_pkg::INDEX_W'(i);
                return res;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Handshakes are sampled at the falling edge, where every signal is settled.
    always @(negedge clk)
    begin
        pick_t want;
        logic  out_taken;
        in_taken = 1'b0;
        out_taken = 1'b0;
        if (rst_n)
        begin
            in_taken = in_valid && in_ready;
            out_taken = out_valid && out_ready;
            if (in_taken)
            begin
                if (req_type == wris_pkg::REQ_SELECT)
                    expected_picks.push_back(predict_pick(exclude_index, entry_limit,
                                                          random_draw));
                else
                    weight_mem[entry_slot] = weight_value;
            end
            if (out_taken)
            begin
                if (expected_picks.size() == 0)
                    report_mismatch($sformatf("unexpected word index=%0d no_draw=%0b",
                                              chosen_index, no_draw));
                else
                begin
                    want = expected_picks.pop_front();
                    if (chosen_index !== want.index)
                        report_mismatch($sformatf("chosen_index %0d, expected %0d",
                                                  chosen_index, want.index));
                    if (no_draw !== want.no_pick)
                        report_mismatch($sformatf("no_draw %0b, expected %0b",
                                                  no_draw, want.no_pick));
                end
            end
            if (in_taken || out_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_word(input logic rt, input logic [wris_pkg::SLOT_W-1:0] slot,
                             input logic [wris_pkg::VALUE_W-1:0] value,
                             input logic [wris_pkg::EXCL_W-1:0] excl,
                             input logic [wris_pkg::COUNT_W-1:0] lim,
                             input logic [wris_pkg::DRAW_W-1:0] draw);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= rt;
        entry_slot    <= slot;
        weight_value  <= value;
        exclude_index <= excl;
        entry_limit   <= lim;
        random_draw   <= draw;
        do @(posedge clk); while (!in_taken);
    endtask

    task automatic send_select(input logic [wris_pkg::EXCL_W-1:0] excl,
                               input logic [wris_pkg::COUNT_W-1:0] lim,
                               input logic [wris_pkg::DRAW_W-1:0] draw);
        send_word(wris_pkg::REQ_SELECT, wris_pkg::SLOT_W'($urandom_range(15)),
                  wris_pkg::VALUE_W'($urandom_range(16'hFFFF)), excl, lim, draw);
    endtask

    task automatic send_random_word(input logic select_only);
        logic [wris_pkg::VALUE_W-1:0] value;
        logic [wris_pkg::EXCL_W-1:0]  excl;
        logic [wris_pkg::COUNT_W-1:0] lim;
        logic [wris_pkg::DRAW_W-1:0]  draw;
        case ($urandom_range(2))
            0: value = wris_pkg::VALUE_W'($urandom_range(3));
            1: value = wris_pkg::VALUE_W'($urandom_range(255));
            default: value = wris_pkg::VALUE_W'($urandom_range(16'hFFFF));
        endcase
        excl = ($urandom_range(9) < 7) ? wris_pkg::EXCL_W'($urandom_range(17)) :
                                         wris_pkg::EXCL_W'($urandom_range(255));
        lim = ($urandom_range(9) < 8) ? wris_pkg::COUNT_W'($urandom_range(16)) :
                                        wris_pkg::COUNT_W'($urandom_range(31));
        case ($urandom_range(9))
            0: draw = '0;
            1: draw = '1;
            default: draw = wris_pkg::DRAW_W'($urandom_range(16'hFFFF));
        endcase
        if (select_only || $urandom_range(3) != 0)
            send_select(excl, lim, draw);
        else
            send_word(wris_pkg::REQ_WRITE, wris_pkg::SLOT_W'($urandom_range(15)), value,
                      excl, lim, draw);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_entry_count(input logic [wris_pkg::COUNT_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        entry_count_m = value;
    endtask

    task automatic test_reset_state();
        send_select(wris_pkg::EXCL_W'($urandom_range(255)), 5'd16,
                    wris_pkg::DRAW_W'($urandom_range(16'hFFFF)));
        send_select(wris_pkg::EXCL_W'($urandom_range(255)), 5'd31,
                    wris_pkg::DRAW_W'($urandom_range(16'hFFFF)));
    endtask

    task automatic test_table_fill();
        logic [wris_pkg::VALUE_W-1:0] value;
        for (int i = 0; i < wris_pkg::MAX_ENTRIES_DEF; i++)
        begin
            case (i)
                0, 1: value = '0;
                2: value = 16'd1;
                3, 15: value = '1;
                default: value = wris_pkg::VALUE_W'($urandom_range(16'hFFFF));
            endcase
            send_word(wris_pkg::REQ_WRITE, wris_pkg::SLOT_W'(i), value,
                      wris_pkg::EXCL_W'($urandom_range(255)),
                      wris_pkg::COUNT_W'($urandom_range(31)),
                      wris_pkg::DRAW_W'($urandom_range(16'hFFFF)));
        end
    endtask

    task automatic test_special_cases();
        set_entry_count(5'd16);
        send_select(8'd255, 5'd1, 16'hFFFF);
        send_select(8'd255, 5'd2, 16'h8000);
        send_select(8'd0, 5'd2, 16'h8000);
        send_select(8'd2, 5'd3, 16'h0000);
        send_select(8'd255, 5'd3, 16'h0000);
        send_select(8'd0, 5'd4, 16'h0000);
        send_select(8'd255, 5'd4, 16'hFFFF);
        send_select(8'd255, 5'd16, 16'h0000);
        set_entry_count(5'd31);
        send_select(8'd15, 5'd31, wris_pkg::DRAW_W'($urandom_range(16'hFFFF)));
        send_select(8'd200, 5'd20, 16'hFFFF);
    endtask

    task automatic run_random_phase(input int tx_pct, input int rx_pct, input int count);
        logic [wris_pkg::COUNT_W-1:0] cnt;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                case ($urandom_range(6))
                    0: cnt = 5'd0;
                    1: cnt = 5'd1;
                    2: cnt = 5'd2;
                    3: cnt = 5'd16;
                    4: cnt = 5'd31;
                    default: cnt = wris_pkg::COUNT_W'($urandom_range(31));
                endcase
                set_entry_count(cnt);
            end
            send_random_word(1'b0);
        end
    endtask

    task automatic test_backpressure();
        set_entry_count(5'd16);
        tx_idle_pct = 0;
        rx_hold_left = HOLD_OFF_CYCLES;
        repeat (8) send_random_word(1'b1);
        wait_idle();
    endtask

    task automatic test_drain_pause();
        set_entry_count(5'd12);
        repeat (6) send_random_word(1'b1);
        in_valid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge clk);
        @(posedge clk);
        repeat (6) send_random_word(1'b1);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        req_type      = wris_pkg::REQ_WRITE;
        entry_slot    = '0;
        weight_value  = '0;
        exclude_index = '0;
        entry_limit   = '0;
        random_draw   = '0;
        out_ready     = 1'b0;
        in_taken      = 1'b0;
        entry_count_m = '0;
        error_count   = 0;
        quiet_cycles  = 0;
        rx_hold_left  = 0;
        tx_idle_pct   = 10;
        rx_idle_pct   = 46;
        for (int i = 0; i < wris_pkg::MAX_ENTRIES_DEF; i++)
            weight_mem[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_table_fill();
        test_special_cases();
        run_random_phase(10, 46, 430);
        test_backpressure();
        run_random_phase(46, 10, 430);
        test_drain_pause();
        run_random_phase(0, 0, 430);
        wait_idle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
sv/wris_pkg.sv
sv/wris_cell.sv
sv/weighted_random_index_select_unit.sv
sv/wris_checker.sv
tb/sv/weighted_random_index_select_unit_tb.sv
